[rtl/sha384_hash_core_assert.svh]
// Assertion macros for the SHA-384 hash core.
// Used by the top level; expects signals named clock and reset in scope.
`ifndef SHA384_HASH_CORE_ASSERT_SVH
`define SHA384_HASH_CORE_ASSERT_SVH

// same-cycle implication
`define SHA384_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SHA384_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/sha384_pkg.sv]
`timescale 1ns / 1ps
// Shared types, widths and constant tables of the SHA-384 hash core.
// No dependencies.
package sha384_pkg;

   localparam int WORD_W         = 64;
   localparam int WIN_DEPTH      = 16;
   localparam int WIN_AW         = 4;
   localparam int ROUNDS         = 80;
   localparam int SCHED_W        = 7;
   localparam int NUM_VARS       = 8;
   localparam int DIGEST_WORDS   = 6;
   localparam int BYTES_PER_WORD = 8;
   localparam int BCOUNT_W       = WORD_W - 3;

   typedef logic [0:NUM_VARS-1][WORD_W-1:0] work_vars_type;

   typedef struct packed {
      logic [WORD_W-1:0] data_word;
      logic [3:0]        valid_bytes;
      logic              is_last;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0] digest_word;
      logic [2:0]        word_index;
      logic              digest_done;
   } rsp_type;

   typedef struct packed {
      logic                push;
      logic [WIN_AW-1:0]   push_slot;
      logic [WORD_W-1:0]   push_data;
      logic [WIN_AW-1:0]   rd_idx;
      logic                expand;
      logic [SCHED_W-1:0]  sched;
   } sched_ctl_type;

   typedef struct packed {
      logic load;
      logic step;
   } round_ctl_type;

   localparam logic [WORD_W-1:0] MARK_WORD = 64'h8000_0000_0000_0000;

   localparam work_vars_type INIT_HASH = '{
      64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17, 64'h152fecd8f70e5939,
      64'h67332667ffc00b31, 64'h8eb44a8768581511, 64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4
   };

   localparam logic [WORD_W-1:0] K_TABLE [ROUNDS] = '{
      64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
      64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
      64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
      64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
      64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
      64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
      64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
      64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
      64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
      64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
      64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
      64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
      64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
      64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
      64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
      64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
      64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
      64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
      64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
      64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
   };

endpackage

[rtl/sha384_ram.sv]
`timescale 1ns / 1ps
// Generic RAM: one write port, two read ports with registered read data.
// Defaults from sha384_pkg.
module sha384_ram import sha384_pkg::*; #(
   parameter int  WIDTH = WORD_W,
   parameter int  DEPTH = WIN_DEPTH,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr0,
   input  logic [AW-1:0]    rd_addr1,
   output logic [WIDTH-1:0] rd_data0,
   output logic [WIDTH-1:0] rd_data1
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data0_ff;
   logic [WIDTH-1:0] rd_data1_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data0_ff <= mem_ff[rd_addr0];
      rd_data1_ff <= mem_ff[rd_addr1];
   end

   assign rd_data0 = rd_data0_ff;
   assign rd_data1 = rd_data1_ff;

endmodule

[rtl/sha384_sched.sv]
`timescale 1ns / 1ps
// Message window in two mirrored RAMs, schedule expansion and W+K stage.
// Depends on sha384_pkg and sha384_ram.
module sha384_sched import sha384_pkg::*; (
   input  logic              clock,
   input  sched_ctl_type     ctl,
   output logic [WORD_W-1:0] wk
);

   logic [WIN_AW-1:0]  wr_addr;
   logic [WORD_W-1:0]  wr_data;
   logic               wr_en;
   logic [WORD_W-1:0]  rd_w15;
   logic [WORD_W-1:0]  rd_w2;
   logic [WORD_W-1:0]  rd_w7;
   logic [WORD_W-1:0]  rd_w16;
   logic [WORD_W-1:0]  w_new;
   logic [SCHED_W-1:0] k_idx;
   logic [WORD_W-1:0]  wk_ff;

   function automatic logic [WORD_W-1:0] small_sigma0(input logic [WORD_W-1:0] x);
      return {x[0], x[63:1]} ^ {x[7:0], x[63:8]} ^ (x >> 7);
   endfunction

   function automatic logic [WORD_W-1:0] small_sigma1(input logic [WORD_W-1:0] x);
      return {x[18:0], x[63:19]} ^ {x[60:0], x[63:61]} ^ (x >> 6);
   endfunction

   assign wr_en   = ctl.push || (ctl.expand && (ctl.sched >= SCHED_W'(WIN_DEPTH)));
   assign wr_addr = ctl.push ? ctl.push_slot : ctl.sched[WIN_AW-1:0];
   assign wr_data = ctl.push ? ctl.push_data : w_new;

   sha384_ram #(.WIDTH(WORD_W), .DEPTH(WIN_DEPTH)) u_ram_a (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_addr0 (ctl.rd_idx - WIN_AW'(15)),
      .rd_addr1 (ctl.rd_idx - WIN_AW'(2)),
      .rd_data0 (rd_w15),
      .rd_data1 (rd_w2)
   );

   sha384_ram #(.WIDTH(WORD_W), .DEPTH(WIN_DEPTH)) u_ram_b (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_addr0 (ctl.rd_idx - WIN_AW'(7)),
      .rd_addr1 (ctl.rd_idx),
      .rd_data0 (rd_w7),
      .rd_data1 (rd_w16)
   );

   always_comb begin
      if (ctl.sched < SCHED_W'(WIN_DEPTH)) begin
         w_new = rd_w16;
      end else begin
         w_new = small_sigma1(rd_w2) + rd_w7 + small_sigma0(rd_w15) + rd_w16;
      end
      k_idx = (ctl.sched < SCHED_W'(ROUNDS)) ? ctl.sched : '0;
   end

   always_ff @(posedge clock) begin
      if (ctl.expand) begin
         wk_ff <= w_new + K_TABLE[k_idx];
      end
   end

   assign wk = wk_ff;

endmodule

[rtl/sha384_round.sv]
`timescale 1ns / 1ps
// Working variables a..h and the SHA-512 round function.
// Depends on sha384_pkg.
module sha384_round import sha384_pkg::*; (
   input  logic              clock,
   input  round_ctl_type     ctl,
   input  work_vars_type     chain,
   input  logic [WORD_W-1:0] wk,
   output work_vars_type     vars
);

   work_vars_type     v_ff;
   work_vars_type     v_in;
   logic [WORD_W-1:0] t1;
   logic [WORD_W-1:0] t2;

   function automatic logic [WORD_W-1:0] big_sigma0(input logic [WORD_W-1:0] x);
      return {x[27:0], x[63:28]} ^ {x[33:0], x[63:34]} ^ {x[38:0], x[63:39]};
   endfunction

   function automatic logic [WORD_W-1:0] big_sigma1(input logic [WORD_W-1:0] x);
      return {x[13:0], x[63:14]} ^ {x[17:0], x[63:18]} ^ {x[40:0], x[63:41]};
   endfunction

   always_comb begin
      t1 = v_ff[7] + big_sigma1(v_ff[4]) + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6])) + wk;
      t2 = big_sigma0(v_ff[0])
         + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
      v_in    = v_ff;
      v_in[7] = v_ff[6];
      v_in[6] = v_ff[5];
      v_in[5] = v_ff[4];
      v_in[4] = v_ff[3] + t1;
      v_in[3] = v_ff[2];
      v_in[2] = v_ff[1];
      v_in[1] = v_ff[0];
      v_in[0] = t1 + t2;
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         v_ff <= chain;
      end else if (ctl.step) begin
         v_ff <= v_in;
      end
   end

   assign vars = v_ff;

endmodule

[rtl/sha384_hash_core.sv]
`timescale 1ns / 1ps
// SHA-384 hash core top level: input sequencer, padding, chaining value, digest output.
// Depends on sha384_pkg, sha384_sched, sha384_round and sha384_hash_core_assert.svh.
`include "sha384_hash_core_assert.svh"
//
// Usage:
// - req channel: one big-endian 64-bit message word per transfer, with the count of
//   valid leading bytes and a last flag. req_ready is high while the core waits for input.
// - A word that does not complete a 16-word block is written straight into the window.
// - The 16th word of a block starts a compression: a..h are loaded in ST_PRIME,
//   ST_ROUND runs schedule and rounds (one round per cycle), and ST_FINAL adds
//   into the chaining value. No new word is taken until the compression ends.
// - On the last word the core appends padding, one window word per cycle, and runs one
//   or two further compressions.
// - rsp channel: six digest words, index 0 first, digest_done on index 5, one per cycle
//   while the receiver takes them. A stalled result holds in the output register and the
//   sequencer waits; the next message is taken as soon as the sixth word is registered.
// - The message window lives in two mirrored 16x64 RAMs; the round loop reads four
//   window words per cycle and writes back the expanded word.
// - Reset (synchronous, active high) loads the initial hash values and clears the
//   counters; the core is ready in the next cycle, with no clearing pass.
//
module sha384_hash_core import sha384_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_PAD   = 3'd1;
   localparam logic [2:0] ST_PRIME = 3'd2;
   localparam logic [2:0] ST_ROUND = 3'd3;
   localparam logic [2:0] ST_FINAL = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;

   localparam logic [1:0] PAD_IDLE = 2'd0;
   localparam logic [1:0] PAD_MARK = 2'd1;
   localparam logic [1:0] PAD_ZERO = 2'd2;
   localparam logic [1:0] PAD_LEN  = 2'd3;

   localparam logic [2:0] LAST_IDX = 3'(DIGEST_WORDS - 1);

   logic [2:0]          state_ff,  state_in;
   logic [1:0]          pad_ff,    pad_in;
   logic [WIN_AW-1:0]   wib_ff,    wib_in;
   logic [BCOUNT_W-1:0] bcount_ff, bcount_in;
   logic [SCHED_W-1:0]  sched_ff,  sched_in;
   logic [2:0]          oidx_ff,   oidx_in;
   work_vars_type       chain_ff,  chain_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff,  rsp_data_in;

   logic [3:0]          nv;
   logic [WORD_W-1:0]   last_word;
   logic                push;
   logic [WORD_W-1:0]   push_data;
   logic                rload;
   logic                rstep;
   sched_ctl_type       sched_ctl;
   round_ctl_type       round_ctl;
   logic [WORD_W-1:0]   wk;
   work_vars_type       vars;
   logic                last_xfer;
   logic                round_end;
   logic                done_word;

   // clip the byte count and build the padded last word
   always_comb begin
      nv = (req_data.valid_bytes > 4'(BYTES_PER_WORD)) ? 4'(BYTES_PER_WORD)
                                                        : req_data.valid_bytes;
      for (int b = 0; b < BYTES_PER_WORD; b++) begin
         if (4'(b) < nv) begin
            last_word[WORD_W-1-8*b -: 8] = req_data.data_word[WORD_W-1-8*b -: 8];
         end else if (4'(b) == nv) begin
            last_word[WORD_W-1-8*b -: 8] = 8'h80;
         end else begin
            last_word[WORD_W-1-8*b -: 8] = 8'h00;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      pad_in       = pad_ff;
      wib_in       = wib_ff;
      bcount_in    = bcount_ff;
      sched_in     = sched_ff;
      oidx_in      = oidx_ff;
      chain_in     = chain_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      push         = 1'b0;
      push_data    = '0;
      rload        = 1'b0;
      rstep        = 1'b0;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               push   = 1'b1;
               wib_in = wib_ff + WIN_AW'(1);
               if (req_data.is_last) begin
                  push_data = last_word;
                  bcount_in = bcount_ff + BCOUNT_W'(nv);
                  pad_in    = (nv == 4'(BYTES_PER_WORD)) ? PAD_MARK : PAD_ZERO;
                  state_in  = ST_PAD;
               end else begin
                  push_data = req_data.data_word;
                  bcount_in = bcount_ff + BCOUNT_W'(BYTES_PER_WORD);
               end
               if (wib_ff == '1) begin
                  state_in = ST_PRIME;
               end
            end
         end
         ST_PAD: begin
            push   = 1'b1;
            wib_in = wib_ff + WIN_AW'(1);
            case (pad_ff)
               PAD_MARK: begin
                  push_data = MARK_WORD;
                  pad_in    = PAD_ZERO;
               end
               PAD_ZERO: begin
                  push_data = '0;
                  if (wib_ff == WIN_AW'(WIN_DEPTH - 2)) begin
                     pad_in = PAD_LEN;
                  end
               end
               PAD_LEN: push_data = {bcount_ff, 3'b000};
               default: push_data = '0;
            endcase
            if (wib_ff == '1) begin
               state_in = ST_PRIME;
            end
         end
         ST_PRIME: begin
            rload    = 1'b1;
            sched_in = '0;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            rstep    = (sched_ff != '0);
            sched_in = sched_ff + SCHED_W'(1);
            if (sched_ff == SCHED_W'(ROUNDS)) begin
               state_in = ST_FINAL;
            end
         end
         ST_FINAL: begin
            for (int i = 0; i < NUM_VARS; i++) begin
               chain_in[i] = chain_ff[i] + vars[i];
            end
            case (pad_ff)
               PAD_LEN: begin
                  oidx_in  = '0;
                  state_in = ST_OUT;
               end
               PAD_IDLE: state_in = ST_IDLE;
               default:  state_in = ST_PAD;
            endcase
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.digest_word  = chain_ff[oidx_ff];
               rsp_data_in.word_index   = oidx_ff;
               rsp_data_in.digest_done  = (oidx_ff == 3'(DIGEST_WORDS - 1));
               oidx_in                  = oidx_ff + 3'd1;
               if (oidx_ff == 3'(DIGEST_WORDS - 1)) begin
                  chain_in  = INIT_HASH;
                  bcount_in = '0;
                  wib_in    = '0;
                  pad_in    = PAD_IDLE;
                  state_in  = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pad_ff       <= PAD_IDLE;
         wib_ff       <= '0;
         bcount_ff    <= '0;
         sched_ff     <= '0;
         oidx_ff      <= '0;
         chain_ff     <= INIT_HASH;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pad_ff       <= pad_in;
         wib_ff       <= wib_in;
         bcount_ff    <= bcount_in;
         sched_ff     <= sched_in;
         oidx_ff      <= oidx_in;
         chain_ff     <= chain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   always_comb begin
      sched_ctl.push      = push;
      sched_ctl.push_slot = wib_ff;
      sched_ctl.push_data = push_data;
      sched_ctl.rd_idx    = (state_ff == ST_ROUND) ? sched_ff[WIN_AW-1:0] + WIN_AW'(1) : '0;
      sched_ctl.expand    = (state_ff == ST_ROUND) && (sched_ff < SCHED_W'(ROUNDS));
      sched_ctl.sched     = sched_ff;
      round_ctl.load      = rload;
      round_ctl.step      = rstep;
   end

   sha384_sched u_sched (
      .clock (clock),
      .ctl   (sched_ctl),
      .wk    (wk)
   );

   sha384_round u_round (
      .clock (clock),
      .ctl   (round_ctl),
      .chain (chain_ff),
      .wk    (wk),
      .vars  (vars)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign last_xfer = req_valid && req_ready && req_data.is_last;
   assign round_end = (state_ff == ST_ROUND) && (sched_ff == SCHED_W'(ROUNDS));
   assign done_word = rsp_valid && rsp_data.digest_done;

   `SHA384_ASSERT_NEXT(a_last_starts_pad, last_xfer, state_ff != ST_IDLE, "last word not padded")
   `SHA384_ASSERT_NEXT(a_round_end, round_end, state_ff == ST_FINAL, "round loop overran")
   `SHA384_ASSERT_NOW(a_done_index, done_word, rsp_data.word_index == LAST_IDX, "early digest_done")

endmodule
